>>> hw/rtl/bcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int TICK_W          = 16;
  localparam int COUNT_W_DEFAULT = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic              ACTIVE_LEVEL_RST = 1'b1;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [TICK_W-1:0] GAP_MIN_RST      = 16'd50;
  localparam logic [TICK_W-1:0] GAP_MAX_RST      = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_GAP_MIN      = 2'd2,
    REG_GAP_MAX      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2,
    CLICK_LONG   = 2'd3
  } click_t;

  typedef struct packed {
    logic              active_level;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] gap_min_ticks;
    logic [TICK_W-1:0] gap_max_ticks;
  } bcc_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/bcc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcc_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface bcc_click_if;
  logic       valid;
  logic       ready;
  logic [1:0] click_event;

  modport source (output valid, output click_event, input ready);
  modport sink   (input valid, input click_event, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bcc_tick.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_tick #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_W_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             key_level,
  input  bcc_pkg::bcc_cfg_t cfg,
  output bcc_pkg::click_t  click_event
);

  localparam int CMP_W = (COUNT_WIDTH > bcc_pkg::TICK_W) ? COUNT_WIDTH : bcc_pkg::TICK_W;

  logic                   press_seen;
  logic                   gesture_done;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] gap_count;

  logic                   press_seen_next;
  logic                   gesture_done_next;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic [COUNT_WIDTH-1:0] gap_count_next;
  logic                   pressed;
  logic [CMP_W-1:0]       hold_w;
  logic [CMP_W-1:0]       gap_w;
  logic [CMP_W-1:0]       long_w;
  logic [CMP_W-1:0]       min_w;
  logic [CMP_W-1:0]       max_w;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    pressed           = (key_level == cfg.active_level);
    press_seen_next   = press_seen;
    gesture_done_next = gesture_done;
    hold_count_next   = hold_count;
    gap_count_next    = gap_count;
    click_event       = bcc_pkg::CLICK_NONE;

    // finished gesture: clear, and rearm once the button is let go
    if (gesture_done) begin
      press_seen_next = 1'b0;
      hold_count_next = '0;
      gap_count_next  = '0;
      if (!pressed) begin
        gesture_done_next = 1'b0;
      end
    end

    if (pressed && !gesture_done_next) begin
      press_seen_next = 1'b1;
      hold_count_next = sat_inc(hold_count_next);
    end

    hold_w = CMP_W'(hold_count_next);
    long_w = CMP_W'(cfg.long_press_ticks);
    min_w  = CMP_W'(cfg.gap_min_ticks);
    max_w  = CMP_W'(cfg.gap_max_ticks);

    if (hold_w > long_w) begin
      gesture_done_next = 1'b1;
      click_event       = bcc_pkg::CLICK_LONG;
      gap_w             = CMP_W'(gap_count_next);
    end else begin
      if (press_seen_next && !pressed) begin
        gap_count_next = sat_inc(gap_count_next);
      end
      gap_w = CMP_W'(gap_count_next);
      if (press_seen_next && gap_w > min_w && gap_w < max_w) begin
        if (pressed) begin
          gesture_done_next = 1'b1;
          click_event       = bcc_pkg::CLICK_DOUBLE;
        end
      end else if (press_seen_next && gap_w > max_w) begin
        gesture_done_next = 1'b1;
        click_event       = bcc_pkg::CLICK_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_seen   <= 1'b0;
      gesture_done <= 1'b0;
      hold_count   <= '0;
      gap_count    <= '0;
    end else if (advance) begin
      press_seen   <= press_seen_next;
      gesture_done <= gesture_done_next;
      hold_count   <= hold_count_next;
      gap_count    <= gap_count_next;
    end
  end

  a_report_arms_wait: assert property (@(posedge clk) disable iff (rst)
    advance && click_event != bcc_pkg::CLICK_NONE |=> gesture_done)
    else $error("report did not set gesture_done");

  a_done_clears_hold: assert property (@(posedge clk) disable iff (rst)
    advance && gesture_done |=> hold_count == '0 && gap_count == '0)
    else $error("counters not cleared after finished gesture");

endmodule

`default_nettype wire

>>> hw/rtl/button_click_classifier.sv
// A key sample moves from the input register through the tick logic into the
// result register. Throughput: one sample per cycle while results are taken;
// the input register loads whenever it is empty or its sample moves on, and its
// sample enters the result register whenever that is empty or being drained.
// Reset (synchronous, rst high): gesture state and counters clear, both pipeline
// stages empty, and the registers return to active-high, 500 / 50 / 300 ticks.
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_W_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::TICK_W-1:0]    cfg_data,
  bcc_key_if.sink                       keys,
  bcc_click_if.source                   clicks
);

  bcc_pkg::bcc_cfg_t cfg;
  logic              s1_valid;
  logic              key_q;
  logic              out_valid;
  bcc_pkg::click_t   out_click;
  bcc_pkg::click_t   click_next;
  logic              out_free;
  logic              advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level     <= bcc_pkg::ACTIVE_LEVEL_RST;
      cfg.long_press_ticks <= bcc_pkg::LONG_PRESS_RST;
      cfg.gap_min_ticks    <= bcc_pkg::GAP_MIN_RST;
      cfg.gap_max_ticks    <= bcc_pkg::GAP_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::REG_ACTIVE_LEVEL: cfg.active_level     <= cfg_data[0];
        bcc_pkg::REG_LONG_PRESS:   cfg.long_press_ticks <= cfg_data;
        bcc_pkg::REG_GAP_MIN:      cfg.gap_min_ticks    <= cfg_data;
        bcc_pkg::REG_GAP_MAX:      cfg.gap_max_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid || clicks.ready;
  assign advance    = s1_valid && out_free;
  assign keys.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (keys.ready) begin
      s1_valid <= keys.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      key_q <= keys.key_level;
    end
  end

  bcc_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .key_level   (key_q),
    .cfg         (cfg),
    .click_event (click_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_click <= click_next;
    end
  end

  assign clicks.valid       = out_valid;
  assign clicks.click_event = out_click;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    keys.valid && keys.ready |=> s1_valid)
    else $error("accepted sample lost from input register");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(key_q))
    else $error("stalled sample changed");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced sample produced no result");

endmodule

`default_nettype wire

>>> tb/click_checker.sv
`timescale 1ns / 1ps

module click_checker
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  bcc_key_if                   keys,
  bcc_click_if                 clicks,
  output int unsigned          mismatches,
  output int unsigned          pending
);

  localparam int CW = COUNT_W_DEFAULT;

  bcc_cfg_t    regs;
  logic        in_gesture;
  logic        await_release;
  logic [CW-1:0] hold_ticks;
  logic [CW-1:0] gap_ticks;
  click_t      expected_clicks[$];
  int unsigned bad_count;
  int unsigned results_seen;

  function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // One scan tick of the classifier; updates the gesture state.
  function automatic click_t predict_click(logic level);
    logic pressed;
    pressed = (level == regs.active_level);
    if (await_release) begin
      in_gesture = 1'b0;
      hold_ticks = '0;
      gap_ticks  = '0;
      if (!pressed) await_release = 1'b0;
    end
    if (pressed && !await_release) begin
      in_gesture = 1'b1;
      hold_ticks = bump(hold_ticks);
    end
    if (hold_ticks > regs.long_press_ticks) begin
      await_release = 1'b1;
      return CLICK_LONG;
    end
    if (in_gesture && !pressed) gap_ticks = bump(gap_ticks);
    // a gap on either window edge falls through to neither branch
    if (in_gesture && gap_ticks > regs.gap_min_ticks && gap_ticks < regs.gap_max_ticks) begin
      if (pressed) begin
        await_release = 1'b1;
        return CLICK_DOUBLE;
      end
    end else if (in_gesture && gap_ticks > regs.gap_max_ticks) begin
      await_release = 1'b1;
      return CLICK_SINGLE;
    end
    return CLICK_NONE;
  endfunction

  always @(posedge clk) begin
    logic [1:0] got;
    click_t     want;
    if (rst) begin
      regs = '{ACTIVE_LEVEL_RST, LONG_PRESS_RST, GAP_MIN_RST, GAP_MAX_RST};
      in_gesture    = 1'b0;
      await_release = 1'b0;
      hold_ticks    = '0;
      gap_ticks     = '0;
      expected_clicks.delete();
      bad_count     = 0;
      results_seen  = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ACTIVE_LEVEL: regs.active_level     = cfg_data[0];
          REG_LONG_PRESS:   regs.long_press_ticks = cfg_data;
          REG_GAP_MIN:      regs.gap_min_ticks    = cfg_data;
          REG_GAP_MAX:      regs.gap_max_ticks    = cfg_data;
          default: ;
        endcase
      end
      if (clicks.valid && clicks.ready) begin
        got = clicks.click_event;
        if (expected_clicks.size() == 0) begin
          if (bad_count < 10)
            $display("%0t: click result %0d #%0d with nothing outstanding",
                     $realtime, got, results_seen);
          bad_count++;
        end else begin
          want = expected_clicks.pop_front();
          if (got !== want) begin
            if (bad_count < 10)
              $display("%0t: click result #%0d expected %s (%0d) got %0d",
                       $realtime, results_seen, want.name(), want, got);
            bad_count++;
          end
        end
        results_seen++;
      end
      if (keys.valid && keys.ready) expected_clicks.push_back(predict_click(keys.key_level));
    end
    mismatches <= bad_count;
    pending    <= expected_clicks.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bcc_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int PARK_CYCLES = 400;
  localparam int PHASE_ITEMS = 130;
  localparam int PHASES      = 9;
  localparam int SAT_RUN     = 24;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;
  int unsigned          mismatches;
  int unsigned          pending;
  bit                   tight;
  bit                   park_req;
  int unsigned          sent;

  bcc_key_if   keys();
  bcc_click_if clicks();

  button_click_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys),
    .clicks    (clicks)
  );

  click_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .keys       (keys),
    .clicks     (clicks),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clip(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic int gap_pick(bcc_cfg_t c);
    int g;
    case ($urandom_range(0, 5))
      0: g = c.gap_min_ticks;
      1: g = c.gap_min_ticks + 1;
      2: g = int'(c.gap_max_ticks) - 1;
      3: g = c.gap_max_ticks;
      4: g = c.gap_max_ticks + 1;
      default: g = $urandom_range(1, 20);
    endcase
    return (g < 1) ? 1 : clip(g, 60);
  endfunction

  function automatic bcc_cfg_t rand_cfg();
    bcc_cfg_t c;
    c.active_level     = 1'($urandom);
    c.long_press_ticks = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
                                                      : TICK_W'($urandom_range(0, 24));
    c.gap_min_ticks    = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
                                                      : TICK_W'($urandom_range(0, 24));
    c.gap_max_ticks    = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
                                                      : TICK_W'($urandom_range(0, 24));
    return c;
  endfunction

  // Offer one key sample and hold it until the transfer.
  task automatic push_key(input logic level);
    int gap;
    gap = tight ? 0 : pick_pause();
    if (gap > 0) begin
      keys.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys.valid     <= 1'b1;
    keys.key_level <= level;
    do @(posedge clk); while (!keys.ready);
    sent++;
  endtask

  task automatic run_level(input logic level, input int n);
    repeat (n) push_key(level);
  endtask

  task automatic wait_drained();
    keys.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(input bcc_cfg_t c);
    reg_idx_t          r;
    logic [TICK_W-1:0] d;
    r = r.first();
    repeat (4) begin
      case (r)
        REG_ACTIVE_LEVEL: begin
          // upper bits are don't-care, fill them with noise
          d    = TICK_W'($urandom);
          d[0] = c.active_level;
        end
        REG_LONG_PRESS: d = c.long_press_ticks;
        REG_GAP_MIN:    d = c.gap_min_ticks;
        default:        d = c.gap_max_ticks;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= d;
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic play_gesture(input bcc_cfg_t c);
    logic on;
    on    = c.active_level;
    tight = ($urandom_range(0, 9) < 3);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4)) push_key(1'($urandom));
      return;
    end
    run_level(on, 1 + $urandom_range(0, clip(c.long_press_ticks + 1, 30)));
    run_level(!on, gap_pick(c));
    if ($urandom_range(0, 1) == 1) begin
      run_level(on, 1 + $urandom_range(0, clip(c.long_press_ticks + 1, 30)));
      run_level(!on, gap_pick(c));
    end
  endtask

  // Result side: random stalls, runs without stalls, one long hold-off on request.
  initial begin
    int stall;
    clicks.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (park_req) begin
        park_req = 1'b0;
        clicks.ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
      end
      clicks.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      stall = ($urandom_range(0, 9) < 3) ? 0 : pick_pause();
      if (stall > 0) begin
        clicks.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (keys.valid && keys.ready) || (clicks.valid && clicks.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bcc_cfg_t    c;
    int unsigned goal;
    bit          paused;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ACTIVE_LEVEL;
    cfg_data       <= '0;
    keys.valid     <= 1'b0;
    keys.key_level <= 1'b0;
    tight    = 1'b0;
    park_req = 1'b0;
    sent     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings
    run_level(1'b1, 2);
    run_level(1'b0, 2);
    wait_drained();

    // single with the gap passing both window edges, double, long press
    set_cfg(bcc_cfg_t'{1'b1, 16'd3, 16'd1, 16'd4});
    run_level(1'b1, 1);
    run_level(1'b0, 6);
    run_level(1'b1, 1);
    run_level(1'b0, 2);
    run_level(1'b1, 1);
    run_level(1'b0, 1);
    run_level(1'b1, 5);
    run_level(1'b0, 1);
    wait_drained();

    // active-low button with an empty gap window
    set_cfg(bcc_cfg_t'{1'b0, 16'd2, 16'd1, 16'd2});
    run_level(1'b0, 1);
    run_level(1'b1, 3);
    run_level(1'b0, 1);
    run_level(1'b1, 2);
    wait_drained();

    // zero thresholds: any press is a long press
    set_cfg(bcc_cfg_t'{1'b1, 16'd0, 16'd0, 16'd0});
    run_level(1'b1, 2);
    run_level(1'b0, 2);
    wait_drained();

    // thresholds at top: long press and release runs, nothing is reported
    set_cfg(bcc_cfg_t'{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    tight = 1'b1;
    run_level(1'b1, SAT_RUN);
    run_level(1'b0, SAT_RUN);
    run_level(1'b1, 1);
    run_level(1'b0, 1);
    tight = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       c = bcc_cfg_t'{1'b0, 16'd0, 16'd0, 16'd0};
        1:       c = bcc_cfg_t'{1'b1, 16'hFFFF, 16'd0, 16'hFFFF};
        2:       c = bcc_cfg_t'{1'b1, 16'd500, 16'd2, 16'd12};
        default: c = rand_cfg();
      endcase
      wait_drained();
      set_cfg(c);
      // fill the pipeline against a long result stall
      if (ph == 3) park_req = 1'b1;
      paused = 1'b0;
      goal   = sent + PHASE_ITEMS;
      while (sent < goal) begin
        play_gesture(c);
        if (ph == 5 && !paused && sent + PHASE_ITEMS / 2 >= goal) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> button_click_classifier.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_if.sv
hw/rtl/bcc_tick.sv
hw/rtl/button_click_classifier.sv
tb/click_checker.sv
tb/tb.sv
